// ===== src/occbp_pkg.sv =====
// Shared types, constants and helpers for the occupancy block OR pooling core.
// Used by every other file of the block; depends on nothing.
package occbp_pkg;

  // default sizing of the block
  localparam int unsigned MAX_WIDTH_DEF  = 1024;
  localparam int unsigned MAX_HEIGHT_DEF = 1024;
  localparam int unsigned MAX_BLOCK_DEF  = 16;

  // fixed field widths
  localparam int unsigned COORD_W  = 10;
  localparam int unsigned BS_REG_W = 5;
  localparam int unsigned GW_REG_W = 11;
  localparam int unsigned GH_REG_W = 11;
  localparam int unsigned CFG_DW   = 11;
  localparam int unsigned CFG_IW   = 2;

  // register indexes
  localparam logic [CFG_IW-1:0] REG_BLOCK_SIZE  = 2'd0;
  localparam logic [CFG_IW-1:0] REG_GRID_WIDTH  = 2'd1;
  localparam logic [CFG_IW-1:0] REG_GRID_HEIGHT = 2'd2;

  // reset values of the registers
  localparam int unsigned BLOCK_SIZE_RST  = 2;
  localparam int unsigned GRID_WIDTH_RST  = 1024;
  localparam int unsigned GRID_HEIGHT_RST = 1024;

  // result queue
  localparam int unsigned Q_DEPTH  = 4;
  localparam int unsigned Q_AW     = 2;
  localparam int unsigned Q_CNT_W  = 3;
  localparam int unsigned Q_CREDIT = 2;

  // control of one cell as it leaves the scan counters
  typedef struct packed {
    logic               first;
    logic               emit;
    logic               last;
    logic [COORD_W-1:0] block_row;
  } scan_t;

  // one finished block
  typedef struct packed {
    logic [COORD_W-1:0] block_row;
    logic [COORD_W-1:0] block_col;
    logic               block_occupied;
    logic               last_block;
  } res_t;

  // index width for a count of n, at least one bit
  function automatic int unsigned idx_w(int unsigned n);
    int unsigned r;
    r = (n > 1) ? $clog2(n) : 1;
    return r;
  endfunction

  // 0 acts as 1, values above hi act as hi
  function automatic int unsigned clamp_range(int unsigned v, int unsigned hi);
    int unsigned r;
    r = (v == 0) ? 1 : ((v > hi) ? hi : v);
    return r;
  endfunction

endpackage

// ===== src/occbp_if.sv =====
// Handshake channels of the occupancy block OR pooling core.
// Depends on occbp_pkg for the coordinate width.
interface occbp_in_if;
  logic valid;
  logic ready;
  logic occupied;

  modport source (output valid, output occupied, input ready);
  modport sink (input valid, input occupied, output ready);
endinterface

interface occbp_res_if;
  logic                             valid;
  logic                             ready;
  logic [occbp_pkg::COORD_W-1:0]    block_row;
  logic [occbp_pkg::COORD_W-1:0]    block_col;
  logic                             block_occupied;
  logic                             last_block;

  modport source (output valid, output block_row, output block_col,
                  output block_occupied, output last_block, input ready);
  modport sink (input valid, input block_row, input block_col,
                input block_occupied, input last_block, output ready);
endinterface

// ===== src/occupancy_block_or_pool_core.sv =====
// Top level of the occupancy block OR pooling core: flag memory pipeline.
// Depends on occbp_pkg, occbp_if, occbp_ram, occbp_scan and occbp_outq.
//
// Usage:
//   in_i carries one grid cell per item (occupied bit) in row-major raster
//   order. out_o carries one item per finished square block: its coarse row
//   and column, the OR of its cells and a flag on the final block of the
//   grid. Edge blocks cover only cells inside the grid.
//   cfg_we_i/cfg_idx_i/cfg_data_i write block_size (0), grid_width (1) and
//   grid_height (2); a write restarts the scan at the first cell. Write only
//   while the block is idle.
// Timing:
//   One cell per cycle sustained while out_o is not stalled. A block result
//   passes from the update stage register into the result queue and shows
//   on out_o right after the edge that writes it to the queue. Each cell
//   does one read-modify-write of the per-column flag memory: read in the
//   accept cycle, write in the next cycle; a cell of the same column right
//   behind gets the new flag by forwarding.
// Reset and stall:
//   Reset clears the counters and the queue and restores the register reset
//   values; the flag memory needs no clearing since each block's first cell
//   writes its flag. When out_o stalls, results collect in the four-entry
//   queue (at most three are ever held) and in_i.ready drops while the queue
//   and the cell in flight together hold more than two results.
module occupancy_block_or_pool_core #(
  parameter int unsigned MAX_WIDTH  = occbp_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = occbp_pkg::MAX_HEIGHT_DEF,
  parameter int unsigned MAX_BLOCK  = occbp_pkg::MAX_BLOCK_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  occbp_in_if.sink                       in_i,
  occbp_res_if.source                    out_o,
  input  logic                           cfg_we_i,
  input  logic [occbp_pkg::CFG_IW-1:0]   cfg_idx_i,
  input  logic [occbp_pkg::CFG_DW-1:0]   cfg_data_i
);

  localparam int unsigned CW = occbp_pkg::idx_w(MAX_WIDTH);

  logic                          in_acc;
  logic [CW-1:0]                 scan_addr;
  occbp_pkg::scan_t              scan_ctl;

  logic                          s1_valid_q;
  logic [CW-1:0]                 s1_addr_q;
  logic                          s1_bit_q;
  occbp_pkg::scan_t              s1_ctl_q;
  logic                          fwd_hit_q, fwd_hit_d;
  logic                          fwd_val_q;

  logic                          rdata;
  logic                          flag_old, flag_new;
  logic                          push;
  occbp_pkg::res_t               push_data;
  logic [occbp_pkg::Q_CNT_W-1:0] q_count;

  assign in_acc = in_i.valid && in_i.ready;

  // keep room in the queue for the item in flight
  assign in_i.ready = (q_count + occbp_pkg::Q_CNT_W'(s1_valid_q && s1_ctl_q.emit))
                      <= occbp_pkg::Q_CNT_W'(occbp_pkg::Q_CREDIT);

  occbp_scan #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_BLOCK (MAX_BLOCK)
  ) u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .adv_i     (in_acc),
    .addr_o    (scan_addr),
    .ctl_o     (scan_ctl)
  );

  occbp_ram #(
    .WIDTH(1),
    .DEPTH(MAX_WIDTH)
  ) u_flags (
    .clk_i  (clk_i),
    .we_i   (s1_valid_q),
    .waddr_i(s1_addr_q),
    .wdata_i(flag_new),
    .re_i   (in_acc),
    .raddr_i(scan_addr),
    .rdata_o(rdata)
  );

  // take the flag just written when the previous cell hit the same column
  assign flag_old = fwd_hit_q ? fwd_val_q : rdata;
  assign flag_new = s1_ctl_q.first ? s1_bit_q : (flag_old | s1_bit_q);
  assign fwd_hit_d = s1_valid_q && (s1_addr_q == scan_addr);

  assign push                     = s1_valid_q && s1_ctl_q.emit;
  assign push_data.block_row      = s1_ctl_q.block_row;
  assign push_data.block_col      = occbp_pkg::COORD_W'(s1_addr_q);
  assign push_data.block_occupied = flag_new;
  assign push_data.last_block     = s1_ctl_q.last;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_addr_q <= scan_addr;
      s1_bit_q  <= in_i.occupied;
      s1_ctl_q  <= scan_ctl;
      fwd_val_q <= flag_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_hit_q  <= 1'b0;
    end else begin
      s1_valid_q <= in_acc;
      if (in_acc) begin
        fwd_hit_q <= fwd_hit_d;
      end
    end
  end

  occbp_outq u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .out_o      (out_o),
    .count_o    (q_count)
  );

  a_stage_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> s1_valid_q)
    else $error("accepted item did not reach the update stage");

  a_fwd_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && fwd_hit_q) |-> $past(s1_valid_q))
    else $error("forwarding without a prior write");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (q_count != occbp_pkg::Q_CNT_W'(occbp_pkg::Q_DEPTH)))
    else $error("result pushed into a full queue");

  a_fwd_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s1_valid_q && (s1_addr_q == scan_addr)) |=> fwd_hit_q)
    else $error("same-column cells not forwarded");

endmodule

// ===== src/occbp_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// A read of the address written in the same cycle returns the old data.
module occbp_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = occbp_pkg::idx_w(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/occbp_scan.sv =====
// Configuration registers and raster scan counters of the pooling core.
// Depends on occbp_pkg; gives the flag address and control of the next cell.
module occbp_scan #(
  parameter int unsigned MAX_WIDTH  = occbp_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = occbp_pkg::MAX_HEIGHT_DEF,
  parameter int unsigned MAX_BLOCK  = occbp_pkg::MAX_BLOCK_DEF,
  localparam int unsigned CW = occbp_pkg::idx_w(MAX_WIDTH),
  localparam int unsigned RW = occbp_pkg::idx_w(MAX_HEIGHT),
  localparam int unsigned BW = occbp_pkg::idx_w(MAX_BLOCK)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [occbp_pkg::CFG_IW-1:0]   cfg_idx_i,
  input  logic [occbp_pkg::CFG_DW-1:0]   cfg_data_i,
  input  logic                           adv_i,
  output logic [CW-1:0]                  addr_o,
  output occbp_pkg::scan_t               ctl_o
);

  localparam int unsigned BS_RST =
    occbp_pkg::clamp_range(occbp_pkg::BLOCK_SIZE_RST, MAX_BLOCK);
  localparam int unsigned W_RST =
    occbp_pkg::clamp_range(occbp_pkg::GRID_WIDTH_RST, MAX_WIDTH);
  localparam int unsigned H_RST =
    occbp_pkg::clamp_range(occbp_pkg::GRID_HEIGHT_RST, MAX_HEIGHT);

  // clamped register values
  logic [BW:0] bs_q, bs_d;
  logic [CW:0] w_q, w_d;
  logic [RW:0] h_q, h_d;

  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [BW-1:0] rib_q, rib_d;
  logic [BW-1:0] cib_q, cib_d;
  logic [CW-1:0] bcol_q, bcol_d;
  logic [RW-1:0] brow_q, brow_d;

  logic row_end, last_row, col_wrap, row_wrap, col_last, row_last, cfg_hit;

  assign row_end  = ((CW+1)'(col_q) + (CW+1)'(1)) == w_q;
  assign last_row = ((RW+1)'(row_q) + (RW+1)'(1)) == h_q;
  assign col_wrap = ((BW+1)'(cib_q) + (BW+1)'(1)) == bs_q;
  assign row_wrap = ((BW+1)'(rib_q) + (BW+1)'(1)) == bs_q;
  assign col_last = col_wrap || row_end;
  assign row_last = row_wrap || last_row;

  assign addr_o          = bcol_q;
  assign ctl_o.first     = (rib_q == '0) && (cib_q == '0);
  assign ctl_o.emit      = col_last && row_last;
  assign ctl_o.last      = row_end && last_row;
  assign ctl_o.block_row = occbp_pkg::COORD_W'(brow_q);

  assign cfg_hit = cfg_we_i && ((cfg_idx_i == occbp_pkg::REG_BLOCK_SIZE) ||
                                (cfg_idx_i == occbp_pkg::REG_GRID_WIDTH) ||
                                (cfg_idx_i == occbp_pkg::REG_GRID_HEIGHT));

  always_comb begin
    bs_d = bs_q;
    w_d  = w_q;
    h_d  = h_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        occbp_pkg::REG_BLOCK_SIZE: begin
          bs_d = (BW+1)'(occbp_pkg::clamp_range(
                   32'(cfg_data_i[occbp_pkg::BS_REG_W-1:0]), MAX_BLOCK));
        end
        occbp_pkg::REG_GRID_WIDTH: begin
          w_d = (CW+1)'(occbp_pkg::clamp_range(
                  32'(cfg_data_i[occbp_pkg::GW_REG_W-1:0]), MAX_WIDTH));
        end
        occbp_pkg::REG_GRID_HEIGHT: begin
          h_d = (RW+1)'(occbp_pkg::clamp_range(
                  32'(cfg_data_i[occbp_pkg::GH_REG_W-1:0]), MAX_HEIGHT));
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    rib_d  = rib_q;
    cib_d  = cib_q;
    bcol_d = bcol_q;
    brow_d = brow_q;
    if (cfg_hit) begin
      // restart the scan at the first cell of a new grid
      col_d  = '0;
      row_d  = '0;
      rib_d  = '0;
      cib_d  = '0;
      bcol_d = '0;
      brow_d = '0;
    end else if (adv_i) begin
      if (row_end) begin
        col_d  = '0;
        cib_d  = '0;
        bcol_d = '0;
        if (last_row) begin
          row_d  = '0;
          rib_d  = '0;
          brow_d = '0;
        end else begin
          row_d = row_q + RW'(1);
          if (row_wrap) begin
            rib_d  = '0;
            brow_d = brow_q + RW'(1);
          end else begin
            rib_d = rib_q + BW'(1);
          end
        end
      end else begin
        col_d = col_q + CW'(1);
        if (col_wrap) begin
          cib_d  = '0;
          bcol_d = bcol_q + CW'(1);
        end else begin
          cib_d = cib_q + BW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bs_q   <= (BW+1)'(BS_RST);
      w_q    <= (CW+1)'(W_RST);
      h_q    <= (RW+1)'(H_RST);
      col_q  <= '0;
      row_q  <= '0;
      rib_q  <= '0;
      cib_q  <= '0;
      bcol_q <= '0;
      brow_q <= '0;
    end else begin
      bs_q   <= bs_d;
      w_q    <= w_d;
      h_q    <= h_d;
      col_q  <= col_d;
      row_q  <= row_d;
      rib_q  <= rib_d;
      cib_q  <= cib_d;
      bcol_q <= bcol_d;
      brow_q <= brow_d;
    end
  end

endmodule

// ===== src/occbp_outq.sv =====
// Small result queue in front of the output channel of the pooling core.
// Depends on occbp_pkg and occbp_res_if; reports its fill level for flow control.
module occbp_outq (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push_i,
  input  occbp_pkg::res_t                 push_data_i,
  occbp_res_if.source                     out_o,
  output logic [occbp_pkg::Q_CNT_W-1:0]   count_o
);

  occbp_pkg::res_t                  ent_q [occbp_pkg::Q_DEPTH];
  logic [occbp_pkg::Q_AW-1:0]       wptr_q, wptr_d;
  logic [occbp_pkg::Q_AW-1:0]       rptr_q, rptr_d;
  logic [occbp_pkg::Q_CNT_W-1:0]    cnt_q, cnt_d;
  logic                             pop;
  occbp_pkg::res_t                  head;

  assign pop  = out_o.valid && out_o.ready;
  assign head = ent_q[rptr_q];

  assign out_o.valid          = (cnt_q != '0);
  assign out_o.block_row      = head.block_row;
  assign out_o.block_col      = head.block_col;
  assign out_o.block_occupied = head.block_occupied;
  assign out_o.last_block     = head.last_block;
  assign count_o              = cnt_q;

  always_comb begin
    wptr_d = push_i ? wptr_q + occbp_pkg::Q_AW'(1) : wptr_q;
    rptr_d = pop ? rptr_q + occbp_pkg::Q_AW'(1) : rptr_q;
    cnt_d  = cnt_q + occbp_pkg::Q_CNT_W'(push_i) - occbp_pkg::Q_CNT_W'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == occbp_pkg::Q_CNT_W'(occbp_pkg::Q_DEPTH)) |-> !push_i)
    else $error("result queue overflow");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop) |=> (cnt_q == $past(cnt_q) + occbp_pkg::Q_CNT_W'(1)))
    else $error("result queue count lost a push");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (wptr_q == rptr_q))
    else $error("result queue pointers disagree with count");

endmodule
